@@ design/bls_pkg.sv @@
// Shared types and codes for the bounded LIFO stack.
// Used by bls_ctrl, bls_datapath and bounded_lifo_stack; no dependencies.
`default_nettype none

package bls_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int WORD_W   = 32;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd5;

    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_VALUE = 2'd1,
        SRC_MEM   = 2'd2
    } t_out_src;

    typedef struct packed {
        logic                write;    // store request word on top
        logic                cnt_inc;
        logic                cnt_dec;
        logic                rd_en;    // read memory, result next cycle
        logic                rd_top;   // read address from count-1, else ptr-1
        logic                out_load;
        t_out_src            out_src;
        logic [STATUS_W-1:0] out_code;
        logic                out_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic ptr_zero;
    } t_stat;

endpackage

`default_nettype wire

@@ design/bls_datapath.sv @@
// Datapath of the bounded LIFO stack: word memory, fill count, read pointer
// and result register. Depends on bls_pkg; driven by bls_ctrl commands.
`default_nettype none

module bls_datapath #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bls_pkg::t_cmd                i_cmd,
    input  wire logic [bls_pkg::WORD_W-1:0]   i_value,
    output bls_pkg::t_stat                    o_stat,
    output logic [bls_pkg::STATUS_W-1:0]      o_status,
    output logic [bls_pkg::WORD_W-1:0]        o_data,
    output logic                              o_last
);
    import bls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_W-1:0]   r_mem [DEPTH];
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_ptr;
    logic [WORD_W-1:0]   r_rd_data;
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_data;
    logic                r_last;

    logic [CW-1:0]       cnt_m1;
    logic [AW-1:0]       rd_addr;
    logic [WORD_W-1:0]   out_word;

    assign cnt_m1  = r_count - CW'(1);
    assign rd_addr = i_cmd.rd_top ? cnt_m1[AW-1:0] : (r_ptr - AW'(1));

    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.ptr_zero = (r_ptr == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= cnt_m1;
        end
    end

    // Single-port word memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_count[AW-1:0]] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_ptr     <= rd_addr;
        end
    end

    always_comb begin
        case (i_cmd.out_src)
            SRC_VALUE: out_word = i_value;
            SRC_MEM:   out_word = r_rd_data;
            default:   out_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_code;
            r_data   <= out_word;
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> !o_stat.full)
        else $error("write while full");

    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> !o_stat.empty && i_cmd.rd_en && i_cmd.rd_top)
        else $error("pop without top read or while empty");

endmodule

`default_nettype wire

@@ design/bls_ctrl.sv @@
// Controller of the bounded LIFO stack: decodes requests and sequences
// memory reads and result hand-off. Depends on bls_pkg.
`default_nettype none

module bls_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [bls_pkg::KIND_W-1:0] i_kind,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    input  wire bls_pkg::t_stat             i_stat,
    output bls_pkg::t_cmd                   o_cmd
);
    import bls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_disp, n_disp;

    always_comb begin
        n_state = r_state;
        n_disp  = r_disp;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_disp = 1'b0;
                    case (i_kind)
                        KIND_PUSH: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_code = ST_OVERFLOW;
                                o_cmd.out_src  = SRC_ZERO;
                            end else begin
                                o_cmd.write    = 1'b1;
                                o_cmd.cnt_inc  = 1'b1;
                                o_cmd.out_code = ST_PUSHED;
                                o_cmd.out_src  = SRC_VALUE;
                            end
                            n_state = S_OUT;
                        end
                        KIND_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                                o_cmd.out_code = ST_UNDERFLOW;
                                o_cmd.out_src  = SRC_ZERO;
                                n_state        = S_OUT;
                            end else begin
                                o_cmd.cnt_dec = 1'b1;
                                o_cmd.rd_en   = 1'b1;
                                o_cmd.rd_top  = 1'b1;
                                n_state       = S_RD;
                            end
                        end
                        KIND_DISP: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                                o_cmd.out_code = ST_EMPTY;
                                o_cmd.out_src  = SRC_ZERO;
                                n_state        = S_OUT;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_top = 1'b1;
                                n_disp       = 1'b1;
                                n_state      = S_RD;
                            end
                        end
                        default: ;  // drop unused request code
                    endcase
                end
            end
            S_RD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_src  = SRC_MEM;
                o_cmd.out_code = r_disp ? ST_ELEMENT : ST_POPPED;
                o_cmd.out_last = !r_disp || i_stat.ptr_zero;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_disp && !i_stat.ptr_zero) begin
                        // advance to the next word down
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_disp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_disp  <= n_disp;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> o_cmd.out_load && o_cmd.out_src == SRC_MEM)
        else $error("memory read not followed by result load");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && !o_cmd.out_load)
        else $error("pending result dropped or overwritten");

endmodule

`default_nettype wire

@@ design/bounded_lifo_stack.sv @@
// Bounded LIFO stack, top level: stream ports around bls_ctrl and
// bls_datapath. Depends on bls_pkg.
//
// A LIFO of up to DEPTH signed 32-bit words. Each input request (tuser) is
// push, pop or display; the push word rides on tdata. Push and every error
// or empty result load the result register on accept and wait in the output
// state until the output is taken; pop first spends a read state on the
// registered read of the single-port word memory; display runs one memory
// read and one output hand-off per stored word. Only one request is in
// flight: s_axis_tready is high while no result is pending.
// No clearing pass follows reset.
`default_nettype none

module bounded_lifo_stack #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] data
    output logic [2:0]       m_axis_tuser,   // [2:0] status
    output logic             m_axis_tlast    // last
);
    import bls_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_kind      (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bls_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (s_axis_tdata),
        .o_stat   (stat),
        .o_status (m_axis_tuser),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ tb/lifo_check_pkg.sv @@
// Scoreboard for the bounded LIFO stack testbench: a shadow stack that works out
// the results of each accepted request, and the queue those results wait in.
// Depends on bls_pkg for the request kinds, status codes and field widths.
package lifo_check_pkg;
    import bls_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
        logic                last;
    } stack_result_t;

    class lifo_scoreboard;
        int unsigned       depth;
        logic [WORD_W-1:0] shadow_stack[$];
        stack_result_t     expected_results[$];
        int unsigned       error_count;
        int unsigned       overflow_hits;
        int unsigned       underflow_hits;

        function new(int unsigned stack_depth);
            depth          = stack_depth;
            error_count    = 0;
            overflow_hits  = 0;
            underflow_hits = 0;
        endfunction

        function int unsigned fill_level();
            return shadow_stack.size();
        endfunction

        function void add_result(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] data,
                                 logic last);
            stack_result_t res;
            res.status = status;
            res.data   = data;
            res.last   = last;
            expected_results.push_back(res);
        endfunction

        function void flag_error(string msg);
            error_count++;
            if (error_count <= 10) begin
                $display("ERROR: %s", msg);
            end
        endfunction

        // Work out every result that one accepted request causes.
        function void note_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
            int                idx;
            logic [WORD_W-1:0] top_word;
            case (kind)
                KIND_PUSH: begin
                    if (shadow_stack.size() >= depth) begin
                        add_result(ST_OVERFLOW, '0, 1'b1);
                        overflow_hits++;
                    end else begin
                        shadow_stack.push_back(value);
                        add_result(ST_PUSHED, value, 1'b1);
                    end
                end
                KIND_POP: begin
                    if (shadow_stack.size() == 0) begin
                        add_result(ST_UNDERFLOW, '0, 1'b1);
                        underflow_hits++;
                    end else begin
                        top_word = shadow_stack.pop_back();
                        add_result(ST_POPPED, top_word, 1'b1);
                    end
                end
                KIND_DISP: begin
                    if (shadow_stack.size() == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        // walk from the top down; the bottom word closes the run
                        for (idx = shadow_stack.size() - 1; idx >= 0; idx--) begin
                            add_result(ST_ELEMENT, shadow_stack[idx], idx == 0);
                        end
                    end
                end
                default: begin
                    // unused request code: dropped by the block
                end
            endcase
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] data,
                                   logic last);
            stack_result_t want;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("unexpected result status=%0d data=%0d last=%0b",
                                     status, $signed(data), last));
            end else begin
                want = expected_results.pop_front();
                if (want.status !== status || want.data !== data || want.last !== last) begin
                    flag_error($sformatf(
                        "result mismatch: expected status=%0d data=%0d last=%0b, got status=%0d data=%0d last=%0b",
                        want.status, $signed(want.data), want.last,
                        status, $signed(data), last));
                end
            end
        endfunction

        function void check_drained();
            if (expected_results.size() != 0) begin
                flag_error($sformatf("%0d expected results never arrived",
                                     expected_results.size()));
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench for bounded_lifo_stack: drives push, pop and display requests
// with random gaps and output stalls, and checks every result in order.
// Depends on bls_pkg, lifo_check_pkg and the bounded_lifo_stack RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;
    import lifo_check_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STACK_DEPTH     = DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] data
    logic [2:0]  m_axis_tuser;         // [2:0] status
    logic        m_axis_tlast;

    lifo_scoreboard stack_check;
    bit             rst_done   = 1'b0;
    bit             send_quiet = 1'b0;
    int unsigned    hold_off_req = 0;

    bounded_lifo_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Offer one request from a falling edge and return at the falling edge after accept.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(5);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = value;
        do @(posedge i_clk); while (!s_axis_tready);
        stack_check.note_request(kind, value);
        @(negedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Bias toward pushes while filling and pops while draining.
    function automatic logic [KIND_W-1:0] pick_kind(bit filling);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 90) return filling ? KIND_PUSH : KIND_POP;
        if (roll < 94) return filling ? KIND_POP : KIND_PUSH;
        if (roll < 97) return KIND_DISP;
        return KIND_UNUSED;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned gap;
        int unsigned taken;
        bit          take_quiet;
        taken      = 0;
        take_quiet = 1'b0;
        wait (rst_done);
        forever begin
            if (hold_off_req != 0) begin
                m_axis_tready = 1'b0;
                repeat (hold_off_req) @(negedge i_clk);
                hold_off_req = 0;
            end
            if (taken % 16 == 0) take_quiet = ($urandom_range(3) == 0);
            gap = take_quiet ? 0 : $urandom_range(5);
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            stack_check.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        logic [KIND_W-1:0] kind;
        int unsigned       n;
        int unsigned       ovf_mark;
        int unsigned       unf_mark;
        bit                filling;
        bit                drained_once;
        bit                full_shown;
        bit                hold_done;
        stack_check = new(STACK_DEPTH);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        // directed: empty-stack errors, extreme words, ignored code, full walk down
        send_request(KIND_POP, 32'h1234_5678);
        send_request(KIND_DISP, 32'hffff_ffff);
        send_request(KIND_PUSH, 32'h7fff_ffff);
        send_request(KIND_PUSH, 32'h8000_0000);
        send_request(KIND_PUSH, 32'h0000_0000);
        send_request(KIND_PUSH, 32'hffff_ffff);
        send_request(KIND_PUSH, 32'haaaa_aaaa);
        send_request(KIND_PUSH, 32'h5555_5555);
        send_request(KIND_DISP, 32'h0000_0000);
        send_request(KIND_UNUSED, 32'hdead_beef);
        send_request(KIND_POP, 32'h0000_0000);
        send_request(KIND_POP, 32'hffff_ffff);
        send_request(KIND_DISP, 32'h5555_5555);
        repeat (4) send_request(KIND_POP, random_word());
        send_request(KIND_DISP, 32'haaaa_aaaa);
        send_request(KIND_POP, 32'h0000_0000);
        send_request(KIND_DISP, 32'h0000_0000);
        send_request(KIND_PUSH, 32'h0000_0001);
        send_request(KIND_UNUSED, 32'h0000_0000);
        send_request(KIND_DISP, 32'h0000_0000);

        // random: alternate fill and drain phases so overflow and underflow both hit
        n            = 0;
        filling      = 1'b1;
        drained_once = 1'b0;
        full_shown   = 1'b0;
        hold_done    = 1'b0;
        ovf_mark     = stack_check.overflow_hits;
        unf_mark     = stack_check.underflow_hits;
        while (n < 136 || !drained_once) begin
            if (n % 20 == 0) send_quiet = ($urandom_range(2) == 0);
            if (n == 40 && !hold_done) begin
                hold_off_req = HOLD_OFF_CYCLES;
                hold_done    = 1'b1;
            end
            if (filling && !full_shown && stack_check.fill_level() == STACK_DEPTH) begin
                send_request(KIND_DISP, random_word());
                full_shown = 1'b1;
                n++;
            end
            kind = pick_kind(filling);
            send_request(kind, random_word());
            if (kind != KIND_UNUSED) n++;
            if (filling && stack_check.overflow_hits >= ovf_mark + 2) begin
                filling  = 1'b0;
                unf_mark = stack_check.underflow_hits;
            end else if (!filling && stack_check.underflow_hits >= unf_mark + 2) begin
                filling      = 1'b1;
                drained_once = 1'b1;
                full_shown   = 1'b0;
                ovf_mark     = stack_check.overflow_hits;
            end
        end
        s_axis_tvalid = 1'b0;

        while (stack_check.expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        stack_check.check_drained();
        if (stack_check.error_count == 0) begin
            $display("bounded_lifo_stack test passed");
        end else begin
            $display("bounded_lifo_stack test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("bounded_lifo_stack test failed");
        $finish;
    end

endmodule

@@ bounded_lifo_stack.f @@
design/bls_pkg.sv
design/bls_datapath.sv
design/bls_ctrl.sv
design/bounded_lifo_stack.sv
tb/lifo_check_pkg.sv
tb/tb.sv
